// File: rtl/ogf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogf_pkg
// Shared widths, constants, stage types and helpers for the orifice flow block.
// ----------------------------------------------------------------------------
package ogf_pkg;

    // fraction format of the mole fractions
    localparam int FRACTION_BITS = 15;
    localparam int ONE_W         = FRACTION_BITS + 1;
    localparam logic [ONE_W-1:0] FRAC_ONE = ONE_W'(1) << FRACTION_BITS;

    // field widths
    localparam int DP_W   = 18;
    localparam int FR_W   = 16;
    localparam int COEF_W = 32;
    localparam int FLOW_W = 24;

    // molecular weights in g/kmol
    localparam logic [15:0] MW_N2  = 16'd28013;
    localparam logic [15:0] MW_O2  = 16'd31999;
    localparam logic [15:0] MW_CO2 = 16'd44010;
    localparam logic [15:0] MW_H2O = 16'd18015;

    // 298 K * 8314 J/(kmol K), 1000 l per m3, 16 * 101325 Pa
    localparam logic [21:0] NUM_CONST = 22'd2477572;
    localparam logic [9:0]  LITRE_K   = 10'd1000;
    localparam logic [20:0] DEN_CONST = 21'd1621200;

    // internal widths
    localparam int MW_W    = 16 + FRACTION_BITS;
    localparam int NUM_W   = 49;
    localparam int SHIFT   = 32 + FRACTION_BITS;
    localparam int FULL_W  = NUM_W + SHIFT;
    localparam int QW      = 48;
    localparam int DW      = MW_W + 21;
    localparam int RW      = DW + 1;
    localparam int ROOT_W  = QW / 2;
    localparam int SQR_W   = ROOT_W + 3;
    localparam int PROD_W  = COEF_W + ROOT_W;
    localparam int X_W     = 33;
    localparam int XM_W    = X_W + 32;

    // rounding and reciprocal of 60 (ceil(2^37 / 60))
    localparam int          RECIP_SH = 37;
    localparam logic [31:0] RECIP_60 = 32'd2290649225;
    localparam logic [X_W-1:0] HALF_60 = X_W'(30);
    localparam int          Q_W      = XM_W - RECIP_SH;
    localparam logic [Q_W-1:0] FLOW_MAX = Q_W'(24'hFFFFFF);

    // long division stage payload
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] low;
    } div_t;

    // square root stage payload
    typedef struct packed {
        logic [QW-1:0]     rad;
        logic [SQR_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqr_t;

    // fraction above one saturates to one
    function automatic logic [ONE_W-1:0] clamp_frac(input logic [FR_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide > 32'(FRAC_ONE))
            return FRAC_ONE;
        else
            return ONE_W'(wide);
    endfunction

endpackage

// File: rtl/ogf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogf_front
// Magnitude, mixture molecular weight, numerator and denominator, four stages.
// ----------------------------------------------------------------------------
module ogf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [ogf_pkg::DP_W-1:0]   pressure_delta,
    input  logic [ogf_pkg::FR_W-1:0]   oxygen_fraction,
    input  logic [ogf_pkg::FR_W-1:0]   carbon_dioxide_fraction,
    input  logic [ogf_pkg::FR_W-1:0]   water_fraction,
    input  logic                       mode,
    output logic                       out_valid,
    output ogf_pkg::div_t              out_data
);
    import ogf_pkg::*;

    // stage 1: clamps, magnitude, products
    logic [DP_W-1:0]     mag;
    logic [ONE_W-1:0]    o2, co2, h2o;
    logic [ONE_W+15:0]   p_o2_reg, p_n2_reg, p_co2_reg, p_h2o_reg;
    logic [ONE_W-1:0]    co2_reg, h2o_reg;
    logic [39:0]         num1_reg;
    logic                mode1_reg, v1_reg;

    always_comb
    begin
        mag = pressure_delta[DP_W-1] ? (~pressure_delta + DP_W'(1)) : pressure_delta;
        o2  = clamp_frac(oxygen_fraction);
        co2 = clamp_frac(carbon_dioxide_fraction);
        h2o = clamp_frac(water_fraction);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_o2_reg  <= (ONE_W+16)'(o2) * (ONE_W+16)'(MW_O2);
            p_n2_reg  <= (ONE_W+16)'(FRAC_ONE - o2) * (ONE_W+16)'(MW_N2);
            p_co2_reg <= (ONE_W+16)'(co2) * (ONE_W+16)'(MW_CO2);
            p_h2o_reg <= (ONE_W+16)'(h2o) * (ONE_W+16)'(MW_H2O);
            num1_reg  <= 40'(mag) * 40'(NUM_CONST);
            co2_reg   <= co2;
            h2o_reg   <= h2o;
            mode1_reg <= mode;
        end
    end

    // stage 2: inhaled weight, exhale partial sum, remainder fraction
    logic [ONE_W:0]     used;
    logic [MW_W-1:0]    mw_in2_reg, exh2_reg;
    logic [ONE_W-1:0]   rest2_reg;
    logic [NUM_W-1:0]   num2_reg;
    logic               mode2_reg, v2_reg;

    assign used = (ONE_W+1)'(co2_reg) + (ONE_W+1)'(h2o_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mw_in2_reg <= MW_W'(p_o2_reg + p_n2_reg);
            exh2_reg   <= MW_W'(p_co2_reg + p_h2o_reg);
            rest2_reg  <= (used < (ONE_W+1)'(FRAC_ONE)) ?
                          ONE_W'((ONE_W+1)'(FRAC_ONE) - used) : '0;
            num2_reg   <= NUM_W'(num1_reg) * NUM_W'(LITRE_K);
            mode2_reg  <= mode1_reg;
        end
    end

    // stage 3: remainder times inhaled weight
    logic [ONE_W+MW_W-1:0] rm3_reg;
    logic [MW_W-1:0]       mw_in3_reg, exh3_reg;
    logic [NUM_W-1:0]      num3_reg;
    logic                  mode3_reg, v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rm3_reg    <= (ONE_W+MW_W)'(rest2_reg) * (ONE_W+MW_W)'(mw_in2_reg);
            mw_in3_reg <= mw_in2_reg;
            exh3_reg   <= exh2_reg;
            num3_reg   <= num2_reg;
            mode3_reg  <= mode2_reg;
        end
    end

    // stage 4: final weight, denominator and first partial remainder
    localparam int ACC_W = MW_W + FRACTION_BITS + 1;
    logic [ACC_W-1:0]  acc;
    logic [MW_W-1:0]   mw;
    logic [FULL_W-1:0] full;
    div_t              d4_next, d4_reg;
    logic              v4_reg;

    always_comb
    begin
        acc  = (ACC_W'(exh3_reg) << FRACTION_BITS) + ACC_W'(rm3_reg);
        mw   = mode3_reg ? mw_in3_reg : MW_W'(acc >> FRACTION_BITS);
        if (mw == '0)
            mw = MW_W'(1);
        full        = FULL_W'(num3_reg) << SHIFT;
        d4_next.den = DW'(DW'(DEN_CONST) * DW'(mw));
        d4_next.rem = RW'(full[FULL_W-1:QW]);
        d4_next.low = full[QW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d4_reg <= d4_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = d4_reg;

endmodule

// File: rtl/ogf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogf_div
// Restoring long division, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ogf_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  ogf_pkg::div_t          in_data,
    output logic                   out_valid,
    output logic [ogf_pkg::QW-1:0] quotient
);
    import ogf_pkg::*;

    div_t st_reg [1:QW];
    logic v_reg  [1:QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        div_t          src;
        logic          src_v;
        logic [RW-1:0] shifted;
        logic          take;
        div_t          nxt;

        // stage input: the request for the first stage, else the stage before
        if (i == 0)
        begin : g_head
            assign src   = in_data;
            assign src_v = in_valid;
        end
        else
        begin : g_body
            assign src   = st_reg[i];
            assign src_v = v_reg[i];
        end

        // shift in next dividend bit, subtract where it fits
        always_comb
        begin
            shifted = {src.rem[RW-2:0], src.low[QW-1]};
            take    = shifted >= RW'(src.den);
            nxt.den = src.den;
            nxt.rem = take ? shifted - RW'(src.den) : shifted;
            nxt.low = {src.low[QW-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[i+1] <= nxt;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= src_v;
        end
    end

    assign out_valid = v_reg[QW];
    assign quotient  = st_reg[QW].low;

endmodule

// File: rtl/ogf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogf_sqrt
// Truncated integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module ogf_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [ogf_pkg::QW-1:0]     radicand,
    output logic                       out_valid,
    output logic [ogf_pkg::ROOT_W-1:0] root
);
    import ogf_pkg::*;

    sqr_t st_reg [1:ROOT_W];
    logic v_reg  [1:ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        sqr_t             src;
        logic             src_v;
        logic [SQR_W-1:0] cur, trial;
        logic             take;
        sqr_t             nxt;

        // stage input: fresh radicand for the first stage, else the stage before
        if (i == 0)
        begin : g_head
            always_comb
            begin
                src.rad  = radicand;
                src.rem  = '0;
                src.root = '0;
                src_v    = in_valid;
            end
        end
        else
        begin : g_body
            assign src   = st_reg[i];
            assign src_v = v_reg[i];
        end

        // bring down two radicand bits and try the next root bit
        always_comb
        begin
            cur      = {src.rem[SQR_W-3:0], src.rad[QW-1:QW-2]};
            trial    = {1'b0, src.root, 2'b01};
            take     = cur >= trial;
            nxt.rad  = {src.rad[QW-3:0], 2'b00};
            nxt.rem  = take ? cur - trial : cur;
            nxt.root = {src.root[ROOT_W-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[i+1] <= nxt;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= src_v;
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign root      = st_reg[ROOT_W].root;

endmodule

// File: rtl/ogf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogf_back
// Coefficient product, rounded division by 60 * 2^24 and saturation.
// ----------------------------------------------------------------------------
module ogf_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [ogf_pkg::ROOT_W-1:0] root,
    input  logic [ogf_pkg::COEF_W-1:0] coefficient,
    output logic                       out_valid,
    output logic [ogf_pkg::FLOW_W-1:0] flow_rate,
    output logic                       saturated
);
    import ogf_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [XM_W-1:0]   xm_reg;
    logic [X_W-1:0]    x;
    logic [Q_W-1:0]    q;
    logic [FLOW_W-1:0] flow_reg;
    logic              sat_reg;
    logic              va_reg, vb_reg, vc_reg;

    // add half a step, scale by the reciprocal of 60
    assign x = X_W'(prod_reg[PROD_W-1:24]) + HALF_60;
    assign q = xm_reg[XM_W-1:RECIP_SH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(coefficient) * PROD_W'(root);
            xm_reg   <= XM_W'(x) * XM_W'(RECIP_60);
            sat_reg  <= q > FLOW_MAX;
            flow_reg <= (q > FLOW_MAX) ? FLOW_W'(FLOW_MAX) : FLOW_W'(q);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign flow_rate = flow_reg;
    assign saturated = sat_reg;

endmodule

// File: rtl/orifice_gas_flow_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orifice_gas_flow_rate
// Orifice plate gas flow from differential pressure and gas composition.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the output is free or being taken,
// and each gives one result after all stages: four stages form the mixture
// weight and the pressure-over-density operands, 48 stages of long division
// give one quotient bit each, 24 stages of square root give one root bit
// each, and three stages scale by the coefficient, divide by 60 and saturate.
// The whole pipeline holds while a result waits at the output. Configuration
// writes take effect at once and should be made with the pipeline empty.
module orifice_gas_flow_rate (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_enable,
    input  logic [ogf_pkg::COEF_W-1:0] cfg_write_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ogf_pkg::DP_W-1:0]   pressure_delta,
    input  logic [ogf_pkg::FR_W-1:0]   oxygen_fraction,
    input  logic [ogf_pkg::FR_W-1:0]   carbon_dioxide_fraction,
    input  logic [ogf_pkg::FR_W-1:0]   water_fraction,
    input  logic                       mode,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ogf_pkg::FLOW_W-1:0] flow_rate,
    output logic                       saturated
);
    import ogf_pkg::*;

    logic              en;
    logic [COEF_W-1:0] coef_reg;
    logic              fv, dv, sv;
    div_t              fd;
    logic [QW-1:0]     quot;
    logic [ROOT_W-1:0] root;

    // pipeline advances unless a result is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // flow coefficient register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= COEF_W'(32'd16777216);
        else if (cfg_write_enable)
            coef_reg <= cfg_write_data;
    end

    ogf_front u_front (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .en                      (en),
        .in_valid                (in_valid),
        .pressure_delta          (pressure_delta),
        .oxygen_fraction         (oxygen_fraction),
        .carbon_dioxide_fraction (carbon_dioxide_fraction),
        .water_fraction          (water_fraction),
        .mode                    (mode),
        .out_valid               (fv),
        .out_data                (fd)
    );

    ogf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv),
        .in_data   (fd),
        .out_valid (dv),
        .quotient  (quot)
    );

    ogf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv),
        .radicand  (quot),
        .out_valid (sv),
        .root      (root)
    );

    ogf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (sv),
        .root        (root),
        .coefficient (coef_reg),
        .out_valid   (out_valid),
        .flow_rate   (flow_rate),
        .saturated   (saturated)
    );

endmodule

// File: rtl/ogf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogf_checker
// Port-level checks on the orifice flow block, bound to the top level.
// ----------------------------------------------------------------------------
module ogf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ogf_pkg::FLOW_W-1:0] flow_rate,
    input logic                       saturated
);
    import ogf_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(flow_rate) && $stable(saturated))
        else $error("result changed while stalled");

    // saturation flag only with the clamped value
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> flow_rate == FLOW_W'(24'hFFFFFF))
        else $error("saturated without full-scale flow");

    // new requests taken whenever the output is free or moving
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready inconsistent with output stall");

endmodule

bind orifice_gas_flow_rate ogf_checker u_ogf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flow_rate (flow_rate),
    .saturated (saturated)
);
